// ===== design/segment_clip_convex_planes_macros.svh =====
// Assertion macros shared by the segment clipper modules.
`ifndef SEGMENT_CLIP_CONVEX_PLANES_MACROS_SVH
`define SEGMENT_CLIP_CONVEX_PLANES_MACROS_SVH

// Checked on every rising edge outside reset.
`define SCCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SCCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sccp_pkg.sv =====
// Types, constants and arithmetic helpers of the segment clipper.
package sccp_pkg;

  localparam int WordW = 32;
  localparam int InDataW = 296;
  localparam int OutDataW = 256;
  localparam int DivSteps = 33;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct packed {
    logic clip;
    logic [2:0] plane_slot;
    logic [1:0] coef_slot;
    word_t coef_value;
    logic [3:0][WordW-1:0] pa;
    logic [3:0][WordW-1:0] pb;
  } item_t;

  // Product of two 33-bit signed operands, kept at 65 bits.
  function automatic logic signed [64:0] mul65(logic signed [32:0] x, logic signed [32:0] y);
    logic signed [65:0] p;
    p = x * y;
    return p[64:0];
  endfunction

  // Floor shift by 16 and saturation of an exact dot product sum.
  function automatic word_t sat_dot(logic signed [65:0] acc);
    logic signed [65:0] s;
    s = acc >>> 16;
    if (s > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

endpackage

// ===== design/sccp_front.sv =====
// Front part: accepts input beats, unpacks them and drops loads to missing planes.
module sccp_front #(
  parameter int MAX_PLANES = 8
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sccp_pkg::InDataW-1:0]  in_tdata,
  input  logic [0:0]                    in_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output sccp_pkg::item_t               q_item
);
  import sccp_pkg::*;

  logic in_range;

  always_comb begin
    q_item.clip       = in_tuser[0];
    q_item.plane_slot = in_tdata[2:0];
    q_item.coef_slot  = in_tdata[4:3];
    q_item.coef_value = in_tdata[36:5];
    for (int k = 0; k < 4; k++) begin
      q_item.pa[k] = in_tdata[37 + 32*k +: 32];
      q_item.pb[k] = in_tdata[165 + 32*k +: 32];
    end
  end

  assign in_range  = int'(q_item.plane_slot) < MAX_PLANES;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && (q_item.clip || in_range);

endmodule

// ===== design/sccp_queue.sv =====
// Short queue of decoded items between the front and the back part.
module sccp_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sccp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output sccp_pkg::item_t head_item
);
  import sccp_pkg::*;
  `include "segment_clip_convex_planes_macros.svh"

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] cnt_r;

  assign full      = cnt_r == CntW'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign head_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(push) - CntW'(pop);
    end
  end

  `SCCP_ASSERT(a_no_overflow, push |-> !full, "push into a full queue")
  `SCCP_ASSERT(a_no_underflow, pop |-> not_empty, "pop from an empty queue")
  `SCCP_ASSERT(a_count_bound, cnt_r <= CntW'(DEPTH), "queue count out of range")

endmodule

// ===== design/sccp_back.sv =====
// Back part: plane table, dot products, interpolation divider and result register.
module sccp_back #(
  parameter int MAX_PLANES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [3:0]                     plane_count,
  input  logic                           q_valid,
  input  sccp_pkg::item_t                q_item,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sccp_pkg::OutDataW-1:0]  out_tdata,
  output logic [0:0]                     out_tuser
);
  import sccp_pkg::*;
  `include "segment_clip_convex_planes_macros.svh"

  localparam int Depth = MAX_PLANES * 4;
  localparam int AW = $clog2(Depth);
  localparam int PW = $clog2(MAX_PLANES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MA, S_MB, S_AC, S_CLS, S_BA, S_BB, S_BS, S_DIV, S_BW, S_OUT
  } state_t;

  state_t state_r;
  word_t mem_r [Depth];
  word_t rdata_r;
  word_t a_r [4];
  word_t b_r [4];
  word_t c_r [4];
  logic [1:0] k_r;
  logic [PW-1:0] plane_r, n_eff_r;
  logic kept_r, repl_a_r;
  logic signed [64:0] prod_r, nacc_r;
  logic signed [65:0] acc_a_r, acc_b_r;
  logic [31:0] wa_r, wb_r;
  logic [32:0] d_r, rem_r, q_r, dv_r;
  logic neg_r;
  logic [5:0] cnt_r;
  logic out_valid_r, out_kept_r;
  logic [OutDataW-1:0] out_data_r;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [PW-1:0] n_eff;
  word_t da, db, res;
  logic signed [64:0] n_sum;
  logic [63:0] mag;
  logic [33:0] trial;
  logic last_plane;

  assign rd_addr    = AW'({plane_r, k_r});
  assign wr_addr    = AW'({q_item.plane_slot, q_item.coef_slot});
  assign n_eff      = (int'(plane_count) > MAX_PLANES) ? PW'(MAX_PLANES) : PW'(plane_count);
  assign da         = sat_dot(acc_a_r);
  assign db         = sat_dot(acc_b_r);
  assign n_sum      = nacc_r + prod_r;
  assign mag        = n_sum[64] ? 64'(-n_sum) : n_sum[63:0];
  assign trial      = {rem_r, dv_r[32]};
  assign res        = neg_r ? (-q_r[31:0] - {31'd0, rem_r != '0}) : q_r[31:0];
  assign last_plane = (plane_r + 1'b1) == n_eff_r;
  assign q_pop      = (state_r == S_IDLE) && q_valid;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kept_r;

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.clip) begin
      mem_r[wr_addr] <= q_item.coef_value;
    end
    rdata_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid && q_item.clip) begin
            for (int k = 0; k < 4; k++) begin
              a_r[k] <= q_item.pa[k];
              b_r[k] <= q_item.pb[k];
            end
            plane_r <= '0;
            n_eff_r <= n_eff;
            kept_r  <= 1'b1;
            k_r     <= '0;
            acc_a_r <= '0;
            acc_b_r <= '0;
            state_r <= (n_eff == '0) ? S_OUT : S_RD;
          end
        end
        S_RD: state_r <= S_MA;
        S_MA: begin
          prod_r  <= mul65(33'(a_r[k_r]), 33'(rdata_r));
          state_r <= S_MB;
        end
        S_MB: begin
          acc_a_r <= acc_a_r + 66'(prod_r);
          prod_r  <= mul65(33'(b_r[k_r]), 33'(rdata_r));
          state_r <= S_AC;
        end
        S_AC: begin
          acc_b_r <= acc_b_r + 66'(prod_r);
          k_r     <= k_r + 1'b1;
          state_r <= (k_r == 2'd3) ? S_CLS : S_RD;
        end
        S_CLS: begin
          k_r <= '0;
          if (da > 0 && db > 0) begin
            kept_r  <= 1'b0;
            state_r <= S_OUT;
          end else if (da > 0) begin
            wa_r     <= 32'(-{db[31], db});
            wb_r     <= da;
            repl_a_r <= 1'b1;
            state_r  <= S_BA;
          end else if (db > 0) begin
            wa_r     <= db;
            wb_r     <= 32'(-{da[31], da});
            repl_a_r <= 1'b0;
            state_r  <= S_BA;
          end else begin
            acc_a_r <= '0;
            acc_b_r <= '0;
            plane_r <= plane_r + 1'b1;
            state_r <= last_plane ? S_OUT : S_RD;
          end
        end
        S_BA: begin
          prod_r  <= mul65({1'b0, wa_r}, 33'(a_r[k_r]));
          d_r     <= 33'(wa_r) + 33'(wb_r);
          state_r <= S_BB;
        end
        S_BB: begin
          nacc_r  <= prod_r;
          prod_r  <= mul65({1'b0, wb_r}, 33'(b_r[k_r]));
          state_r <= S_BS;
        end
        S_BS: begin
          neg_r   <= n_sum[64];
          rem_r   <= 33'(mag[63:33]);
          dv_r    <= mag[32:0];
          q_r     <= '0;
          cnt_r   <= 6'(DivSteps - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (trial >= {1'b0, d_r}) begin
            rem_r <= 33'(trial - {1'b0, d_r});
            q_r   <= {q_r[31:0], 1'b1};
          end else begin
            rem_r <= trial[32:0];
            q_r   <= {q_r[31:0], 1'b0};
          end
          dv_r  <= {dv_r[31:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_BW;
          end
        end
        S_BW: begin
          c_r[k_r] <= res;
          k_r      <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            for (int k = 0; k < 3; k++) begin
              if (repl_a_r) begin
                a_r[k] <= c_r[k];
              end else begin
                b_r[k] <= c_r[k];
              end
            end
            if (repl_a_r) begin
              a_r[3] <= res;
            end else begin
              b_r[3] <= res;
            end
            acc_a_r <= '0;
            acc_b_r <= '0;
            plane_r <= plane_r + 1'b1;
            state_r <= last_plane ? S_OUT : S_RD;
          end else begin
            state_r <= S_BA;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_kept_r  <= kept_r;
            for (int k = 0; k < 4; k++) begin
              out_data_r[32*k +: 32]       <= kept_r ? a_r[k] : '0;
              out_data_r[128 + 32*k +: 32] <= kept_r ? b_r[k] : '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SCCP_ASSERT(a_rem_below_divisor, (state_r == S_DIV) |-> (rem_r < d_r),
               "divider remainder not below divisor")
  `SCCP_ASSERT(a_plane_in_range, (state_r == S_CLS) |-> (plane_r < n_eff_r),
               "plane index past the plane count")
  `SCCP_ASSERT(a_divisor_nonzero, (state_r == S_BS) |-> (d_r != '0),
               "interpolation weight sum is zero")
  `SCCP_ASSERT(a_pop_only_idle, q_pop |-> (state_r == S_IDLE),
               "queue popped while an item is in work")

endmodule

// ===== design/segment_clip_convex_planes.sv =====
// Top level of the segment clipper against a table of convex homogeneous planes.
//
//   Channel  Direction  Payload
//   in_      slave      tdata: plane_slot, coef_slot, coef_value, a_x..a_w, b_x..b_w; tuser: func
//   out_     master     tdata: out_a_x..out_a_w, out_b_x..out_b_w; tuser: kept
//   cfg_     write      plane_count
//
// A load beat is written to the plane table when the back part pops it. A clip beat
// runs dot products and classification for each plane applied, and an interpolation
// for each plane that cuts the segment, using serial multiplies into one product
// register and the one-bit-per-cycle divider; a dropped segment skips its remaining planes.
// Reset is synchronous and active low; the plane table is not cleared.
// The input queue accepts beats while the back part works or the output stalls, until full.
module segment_clip_convex_planes #(
  parameter int MAX_PLANES = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // plane_slot, coef_slot, coef_value, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
  input  logic [sccp_pkg::InDataW-1:0]  in_tdata,
  // func
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_a_x, out_a_y, out_a_z, out_a_w, out_b_x, out_b_y, out_b_z, out_b_w
  output logic [sccp_pkg::OutDataW-1:0] out_tdata,
  // kept
  output logic [0:0]                    out_tuser,
  input  logic                          cfg_we,
  input  logic [3:0]                    cfg_wdata
);
  import sccp_pkg::*;

  logic [3:0] plane_count_r;
  logic q_full, q_push, q_pop, q_valid;
  item_t push_item, head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= '0;
    end else if (cfg_we) begin
      plane_count_r <= cfg_wdata;
    end
  end

  sccp_front #(.MAX_PLANES(MAX_PLANES)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  sccp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (head_item)
  );

  sccp_back #(.MAX_PLANES(MAX_PLANES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .plane_count (plane_count_r),
    .q_valid     (q_valid),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
